// ===== rtl/core/quadratic_root_solver_macros.svh =====
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH
// Assert that a property holds on every clock edge outside reset.
`define QRS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assert a property that is checked during reset too.
`define QRS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/core/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants and types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ROOT_WIDTH     = 34;
  localparam int KIND_WIDTH     = 3;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_NONE   = 3'd0,
    KIND_DOUBLE = 3'd1,
    KIND_TWO    = 3'd2,
    KIND_LINEAR = 3'd3,
    KIND_DEGEN  = 3'd4
  } root_kind_t;
endpackage

// ===== rtl/core/qrs_if.sv =====
// ----------------------------------------------------------------------------
// qrs_coef_if / qrs_root_if
// Valid/ready channels for coefficient and root beats.
// ----------------------------------------------------------------------------
interface qrs_coef_if #(parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
  logic                                    valid;
  logic                                    ready;
  logic [qrs_pkg::KIND_WIDTH-1:0]          root_kind;
  logic signed [qrs_pkg::ROOT_WIDTH-1:0]   root_plus;
  logic signed [qrs_pkg::ROOT_WIDTH-1:0]   root_minus;
  modport source (output valid, root_kind, root_plus, root_minus, input ready);
  modport sink (input valid, root_kind, root_plus, root_minus, output ready);
endinterface

// ===== rtl/core/qrs_divider.sv =====
// ----------------------------------------------------------------------------
// qrs_divider
// Pipelined signed restoring divider, one quotient bit per stage,
// truncating toward zero. Carries a tag alongside each beat.
// ----------------------------------------------------------------------------
module qrs_divider #(
  parameter int NUM_WIDTH = 56,
  parameter int DEN_WIDTH = 34,
  parameter int TAG_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        in_valid,
  input  logic signed [NUM_WIDTH-1:0] num,
  input  logic signed [DEN_WIDTH-1:0] den,
  input  logic [TAG_WIDTH-1:0]        tag_in,
  output logic                        out_valid,
  output logic signed [NUM_WIDTH-1:0] quot,
  output logic [TAG_WIDTH-1:0]        tag_out
);
  localparam int REM_WIDTH = DEN_WIDTH + 1;

  logic                 vld   [NUM_WIDTH+1];
  logic [NUM_WIDTH-1:0] qn    [NUM_WIDTH+1];
  logic [REM_WIDTH-1:0] rem   [NUM_WIDTH+1];
  logic [DEN_WIDTH-1:0] dmag  [NUM_WIDTH+1];
  logic                 neg   [NUM_WIDTH+1];
  logic [TAG_WIDTH-1:0] tag   [NUM_WIDTH+1];

  always_comb begin
    vld[0]  = in_valid;
    qn[0]   = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
    dmag[0] = den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : DEN_WIDTH'(den);
    neg[0]  = num[NUM_WIDTH-1] ^ den[DEN_WIDTH-1];
    rem[0]  = '0;
    tag[0]  = tag_in;
  end

  for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_stage
    logic [REM_WIDTH-1:0] trial;
    logic                 fit;
    always_comb begin
      trial = {rem[s][REM_WIDTH-2:0], qn[s][NUM_WIDTH-1]};
      fit   = trial >= {1'b0, dmag[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (advance) begin
        vld[s+1] <= vld[s];
      end
      if (advance) begin
        rem[s+1]  <= fit ? trial - {1'b0, dmag[s]} : trial;
        qn[s+1]   <= {qn[s][NUM_WIDTH-2:0], fit};
        dmag[s+1] <= dmag[s];
        neg[s+1]  <= neg[s];
        tag[s+1]  <= tag[s];
      end
    end
  end

  assign out_valid = vld[NUM_WIDTH];
  assign quot      = neg[NUM_WIDTH] ? NUM_WIDTH'(-qn[NUM_WIDTH]) : qn[NUM_WIDTH];
  assign tag_out   = tag[NUM_WIDTH];
endmodule

// ===== rtl/core/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined fixed-point square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int D_WIDTH   = 34,
  parameter int FRAC_BITS = 16,
  parameter int TAG_WIDTH = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   advance,
  input  logic                                   in_valid,
  input  logic [D_WIDTH-1:0]                     d,
  input  logic [TAG_WIDTH-1:0]                   tag_in,
  output logic                                   out_valid,
  output logic [(D_WIDTH+1)/2+FRAC_BITS-1:0]     root,
  output logic [TAG_WIDTH-1:0]                   tag_out
);
  localparam int HALF    = (D_WIDTH + 1) / 2;
  localparam int STEPS   = HALF + FRAC_BITS;
  localparam int R_WIDTH = STEPS;
  localparam int X_WIDTH = 2 * STEPS;
  localparam int M_WIDTH = R_WIDTH + 2;

  logic                 vld  [STEPS+1];
  logic [X_WIDTH-1:0]   x    [STEPS+1];
  logic [M_WIDTH-1:0]   rem  [STEPS+1];
  logic [R_WIDTH-1:0]   rt   [STEPS+1];
  logic [TAG_WIDTH-1:0] tag  [STEPS+1];

  always_comb begin
    vld[0] = in_valid;
    x[0]   = {{(X_WIDTH-D_WIDTH-2*FRAC_BITS){1'b0}}, d, {(2*FRAC_BITS){1'b0}}};
    rem[0] = '0;
    rt[0]  = '0;
    tag[0] = tag_in;
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    logic [M_WIDTH-1:0] trial;
    logic [M_WIDTH-1:0] cand;
    logic               fit;
    always_comb begin
      trial = {rem[s][M_WIDTH-3:0], x[s][X_WIDTH-1 -: 2]};
      cand  = {rt[s], 2'b01};
      fit   = trial >= cand;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (advance) begin
        vld[s+1] <= vld[s];
      end
      if (advance) begin
        rem[s+1] <= fit ? trial - cand : trial;
        rt[s+1]  <= {rt[s][R_WIDTH-2:0], fit};
        x[s+1]   <= {x[s][X_WIDTH-3:0], 2'b00};
        tag[s+1] <= tag[s];
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign root      = rt[STEPS];
  assign tag_out   = tag[STEPS];
endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// Throughput: one equation per cycle while the output is not stalled; the square-root and divider pipelines
// each retire one result bit per stage, and the output register sets the pace.
// A stalled output freezes the whole pipeline in place.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2+b*x+c=0 in signed fixed point.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input logic              clk,
  input logic              rst,
  qrs_coef_if.sink         coef,
  qrs_root_if.source       root
);
  localparam int CW   = COEF_WIDTH;
  localparam int PW   = 2 * CW;
  localparam int DW   = 2 * CW + 2;
  localparam int NW   = DW + FRAC_BITS + 1;
  localparam int DENW = CW + 2;
  localparam int KW   = qrs_pkg::KIND_WIDTH;
  localparam int RW   = qrs_pkg::ROOT_WIDTH;
  localparam int SRW  = (DW + 1) / 2 + FRAC_BITS;
  localparam int TW   = KW + DENW + NW;

  logic advance;
  assign advance   = !root.valid || root.ready;
  assign coef.ready = advance;

  // stage 1: products
  logic                  s1_valid;
  logic signed [PW-1:0]  s1_bb, s1_ac;
  logic signed [CW-1:0]  s1_a, s1_b, s1_c;
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (advance) s1_valid <= coef.valid;
    if (advance) begin
      s1_bb <= PW'(coef.coef_b * coef.coef_b);
      s1_ac <= PW'(coef.coef_a * coef.coef_c);
      s1_a  <= coef.coef_a;
      s1_b  <= coef.coef_b;
      s1_c  <= coef.coef_c;
    end
  end

  // stage 2: discriminant, kind, numerator base, denominator
  logic                   s2_valid;
  logic signed [DW-1:0]   s2_d;
  logic [KW-1:0]          s2_kind;
  logic signed [NW-1:0]   s2_nb;
  logic signed [DENW-1:0] s2_den;
  logic signed [DW-1:0]   d_c;
  logic [KW-1:0]          kind_c;
  assign d_c = DW'(s1_bb) - (DW'(s1_ac) <<< 2);
  always_comb begin
    priority if (s1_a == '0 && s1_b == '0) kind_c = qrs_pkg::KIND_DEGEN;
    else if (s1_a == '0) kind_c = qrs_pkg::KIND_LINEAR;
    else if (d_c < 0)    kind_c = qrs_pkg::KIND_NONE;
    else if (d_c == '0)  kind_c = qrs_pkg::KIND_DOUBLE;
    else                 kind_c = qrs_pkg::KIND_TWO;
  end
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (advance) s2_valid <= s1_valid;
    if (advance) begin
      s2_d    <= d_c;
      s2_kind <= kind_c;
      if (s1_a == '0) begin
        s2_nb  <= -(NW'(s1_c) <<< FRAC_BITS);
        s2_den <= DENW'(s1_b);
      end else begin
        s2_nb  <= -(NW'(s1_b) <<< FRAC_BITS);
        s2_den <= DENW'(s1_a) <<< 1;
      end
    end
  end

  // square root
  logic            sq_valid;
  logic [SRW-1:0]  sq_root;
  logic [TW-1:0]   sq_tag;
  qrs_sqrt #(.D_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .TAG_WIDTH(TW)) u_sqrt (
    .clk, .rst, .advance,
    .in_valid(s2_valid),
    .d(s2_d[DW-1] ? '0 : s2_d),
    .tag_in({s2_kind, s2_den, s2_nb}),
    .out_valid(sq_valid), .root(sq_root), .tag_out(sq_tag)
  );

  // stage 3: numerators
  logic                   s3_valid;
  logic [KW-1:0]          s3_kind;
  logic signed [NW-1:0]   s3_np, s3_nm;
  logic signed [DENW-1:0] s3_den;
  logic signed [NW-1:0]   s_ext;
  logic [KW-1:0]          t_kind;
  logic signed [NW-1:0]   t_nb;
  assign t_kind = sq_tag[TW-1 -: KW];
  assign t_nb   = sq_tag[NW-1:0];
  assign s_ext  = (t_kind == qrs_pkg::KIND_TWO) ? NW'(sq_root) : '0;
  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (advance) s3_valid <= sq_valid;
    if (advance) begin
      s3_kind <= t_kind;
      s3_np   <= t_nb + s_ext;
      s3_nm   <= t_nb - s_ext;
      s3_den  <= (t_kind == qrs_pkg::KIND_DEGEN) ? DENW'(1) : sq_tag[NW +: DENW];
    end
  end

  logic                 dp_valid, dm_valid;
  logic signed [NW-1:0] qp, qm;
  logic [KW-1:0]        dp_kind, dm_kind;
  qrs_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(DENW), .TAG_WIDTH(KW)) u_div_plus (
    .clk, .rst, .advance, .in_valid(s3_valid), .num(s3_np), .den(s3_den),
    .tag_in(s3_kind), .out_valid(dp_valid), .quot(qp), .tag_out(dp_kind)
  );
  qrs_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(DENW), .TAG_WIDTH(KW)) u_div_minus (
    .clk, .rst, .advance, .in_valid(s3_valid), .num(s3_nm), .den(s3_den),
    .tag_in(s3_kind), .out_valid(dm_valid), .quot(qm), .tag_out(dm_kind)
  );

  // output register
  logic zero_out;
  assign zero_out = dp_kind == qrs_pkg::KIND_NONE || dp_kind == qrs_pkg::KIND_DEGEN;
  always_ff @(posedge clk) begin
    if (rst) root.valid <= 1'b0;
    else if (advance) root.valid <= dp_valid & dm_valid;
    if (advance) begin
      root.root_kind  <= dp_kind | dm_kind;
      root.root_plus  <= zero_out ? '0 : RW'(qp);
      root.root_minus <= zero_out ? '0 : RW'(qm);
    end
  end
endmodule

// ===== rtl/core/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_macros.svh"
module qrs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            in_ready,
  input logic [qrs_pkg::KIND_WIDTH-1:0]  root_kind,
  input logic [qrs_pkg::ROOT_WIDTH-1:0]  root_plus,
  input logic [qrs_pkg::ROOT_WIDTH-1:0]  root_minus
);
  `QRS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "valid after reset")
  `QRS_ASSERT(a_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(root_plus), "beat dropped")
  `QRS_ASSERT(a_stall, clk, rst, out_valid && !out_ready |-> !in_ready, "accepts while stalled")
  `QRS_ASSERT(a_zero, clk, rst,
    out_valid && (root_kind == qrs_pkg::KIND_NONE || root_kind == qrs_pkg::KIND_DEGEN)
      |-> root_plus == '0 && root_minus == '0, "nonzero root")
  `QRS_ASSERT(a_kind, clk, rst, out_valid |-> root_kind <= qrs_pkg::KIND_DEGEN, "bad kind")
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk(clk), .rst(rst), .out_valid(root.valid), .out_ready(root.ready),
  .in_ready(coef.ready), .root_kind(root.root_kind),
  .root_plus(root.root_plus), .root_minus(root.root_minus)
);
